[rtl/core/ict_pkg.sv]
// Types, widths and step functions for the incircle test pipeline.
package ict_pkg;

  localparam int COORD_W    = 16;
  localparam int MARGIN_W   = 16;
  localparam int OUT_W      = 32;
  localparam int NUM_W      = 50;
  localparam int DEN_W      = 35;
  localparam int DIV_STEPS  = NUM_W;
  localparam int OX_W       = NUM_W + 1;
  localparam int DIFF_W     = OX_W + 1;
  localparam int MAG_W      = 50;
  localparam int HALF_W     = MAG_W / 2;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int RAD_W      = 102;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 2;

  localparam logic signed [OX_W-1:0] OX_MAX = OX_W'(32'sh7FFF_FFFF);
  localparam logic signed [OX_W-1:0] OX_MIN = OX_W'(32'sh8000_0000);

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
  } in_word_t;

  typedef struct packed {
    logic                    inside_res;
    logic                    degenerate;
    logic signed [OUT_W-1:0] centre_x;
    logic signed [OUT_W-1:0] centre_y;
    logic [OUT_W-1:0]        radius;
  } out_word_t;

  typedef struct packed {
    logic [NUM_W-1:0]          num_x;
    logic [NUM_W-1:0]          num_y;
    logic [NUM_W-1:0]          q_x;
    logic [NUM_W-1:0]          q_y;
    logic [DEN_W-1:0]          rem_x;
    logic [DEN_W-1:0]          rem_y;
    logic [DEN_W-1:0]          den;
    logic                      neg_x;
    logic                      neg_y;
    logic                      deg;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } div_t;

  typedef struct packed {
    logic [RAD_W-1:0]       rad_a;
    logic [RAD_W-1:0]       rad_p;
    logic [REM_W-1:0]       rem_a;
    logic [REM_W-1:0]       rem_p;
    logic [ROOT_W-1:0]      root_a;
    logic [ROOT_W-1:0]      root_p;
    logic                   deg;
    logic signed [OX_W-1:0] ox;
    logic signed [OX_W-1:0] oy;
  } sqr_t;

  // restoring division step: {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                              input logic nbit,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      return {1'b1, DEN_W'(trial - {1'b0, den})};
    end
    return {1'b0, trial[DEN_W-1:0]};
  endfunction

  // digit-by-digit square root step: {root bit, new remainder}
  function automatic logic [REM_W:0] sqrt_step(input logic [REM_W-1:0] rem,
                                               input logic [1:0] pair,
                                               input logic [ROOT_W-1:0] root);
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] t;
    r2 = {rem, pair};
    t  = (REM_W+2)'({root, 2'b01});
    if (r2 >= t) begin
      return {1'b1, REM_W'(r2 - t)};
    end
    return {1'b0, r2[REM_W-1:0]};
  endfunction

  function automatic logic [OUT_W-1:0] sat_s32(input logic signed [OX_W-1:0] v);
    if (v > OX_MAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < OX_MIN) begin
      return 32'h8000_0000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

[rtl/core/incircle_test_unit.sv]
// Incircle test: pipelined circumcircle predicate over signed Q8.8 points.
// Takes one word per cycle when no result is held or result_ready is high,
// and returns one result word per input word, in order. The 50-step
// restoring divider forms the circumcentre and the 51-step square root
// forms radius and query distance, each one bit per pipeline stage.
// A stalled result freezes the whole pipeline; nothing is dropped.
module incircle_test_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           query_valid,
  output logic                           query_ready,
  input  ict_pkg::in_word_t              query,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ict_pkg::out_word_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ict_pkg::MARGIN_W-1:0]   cfg_data
);

  localparam int NW = ict_pkg::NUM_W;
  localparam int DW = ict_pkg::DEN_W;
  localparam int DS = ict_pkg::DIV_STEPS;
  localparam int SS = ict_pkg::SQRT_STEPS;
  localparam int OW = ict_pkg::OX_W;
  localparam int RW = ict_pkg::ROOT_W;
  localparam int MW = ict_pkg::MAG_W;
  localparam int HW = ict_pkg::HALF_W;

  logic                          adv;
  logic [ict_pkg::MARGIN_W-1:0]  inside_margin;

  assign adv         = !result_valid || result_ready;
  assign query_ready = adv;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_margin <= '0;
    end else if (cfg_valid) begin
      inside_margin <= cfg_data;
    end
  end

  // valid bits
  logic          s1_v, s2_v, s3_v, s4_v, o_v;
  logic [DS:0]   dv_v;
  logic [3:0]    e_v;
  logic [SS:0]   sq_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      dv_v <= '0;
      o_v  <= 1'b0;
      e_v  <= '0;
      sq_v <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_v <= query_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      dv_v <= {dv_v[DS-1:0], s4_v};
      o_v  <= dv_v[DS];
      e_v  <= {e_v[2:0], o_v};
      sq_v <= {sq_v[SS-1:0], e_v[3]};
      result_valid <= sq_v[SS];
    end
  end

  // stage 1: coordinate differences and squares
  logic signed [15:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy, s1_px, s1_py;
  logic signed [16:0] s1_dy_bc, s1_dy_ca, s1_dy_ab, s1_dx_cb, s1_dx_ac, s1_dx_ba;
  logic signed [31:0] s1_sq_ax, s1_sq_ay, s1_sq_bx, s1_sq_by, s1_sq_cx, s1_sq_cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax <= query.vert_a_x;
      s1_ay <= query.vert_a_y;
      s1_bx <= query.vert_b_x;
      s1_by <= query.vert_b_y;
      s1_cx <= query.vert_c_x;
      s1_cy <= query.vert_c_y;
      s1_px <= query.query_x;
      s1_py <= query.query_y;
      s1_dy_bc <= 17'(query.vert_b_y) - 17'(query.vert_c_y);
      s1_dy_ca <= 17'(query.vert_c_y) - 17'(query.vert_a_y);
      s1_dy_ab <= 17'(query.vert_a_y) - 17'(query.vert_b_y);
      s1_dx_cb <= 17'(query.vert_c_x) - 17'(query.vert_b_x);
      s1_dx_ac <= 17'(query.vert_a_x) - 17'(query.vert_c_x);
      s1_dx_ba <= 17'(query.vert_b_x) - 17'(query.vert_a_x);
      s1_sq_ax <= 32'(query.vert_a_x) * 32'(query.vert_a_x);
      s1_sq_ay <= 32'(query.vert_a_y) * 32'(query.vert_a_y);
      s1_sq_bx <= 32'(query.vert_b_x) * 32'(query.vert_b_x);
      s1_sq_by <= 32'(query.vert_b_y) * 32'(query.vert_b_y);
      s1_sq_cx <= 32'(query.vert_c_x) * 32'(query.vert_c_x);
      s1_sq_cy <= 32'(query.vert_c_y) * 32'(query.vert_c_y);
    end
  end

  // stage 2: determinant terms and squared norms
  logic signed [15:0] s2_ax, s2_ay, s2_px, s2_py;
  logic signed [16:0] s2_dy_bc, s2_dy_ca, s2_dy_ab, s2_dx_cb, s2_dx_ac, s2_dx_ba;
  logic signed [33:0] s2_t_a, s2_t_b, s2_t_c, s2_asq, s2_bsq, s2_csq;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ax <= s1_ax;
      s2_ay <= s1_ay;
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_dy_bc <= s1_dy_bc;
      s2_dy_ca <= s1_dy_ca;
      s2_dy_ab <= s1_dy_ab;
      s2_dx_cb <= s1_dx_cb;
      s2_dx_ac <= s1_dx_ac;
      s2_dx_ba <= s1_dx_ba;
      s2_t_a <= 34'(s1_ax) * 34'(s1_dy_bc);
      s2_t_b <= 34'(s1_bx) * 34'(s1_dy_ca);
      s2_t_c <= 34'(s1_cx) * 34'(s1_dy_ab);
      s2_asq <= 34'(s1_sq_ax) + 34'(s1_sq_ay);
      s2_bsq <= 34'(s1_sq_bx) + 34'(s1_sq_by);
      s2_csq <= 34'(s1_sq_cx) + 34'(s1_sq_cy);
    end
  end

  // stage 3: determinant and numerator terms
  logic signed [15:0] s3_ax, s3_ay, s3_px, s3_py;
  logic signed [35:0] s3_d;
  logic signed [49:0] s3_nxa, s3_nxb, s3_nxc, s3_nya, s3_nyb, s3_nyc;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax <= s2_ax;
      s3_ay <= s2_ay;
      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_d  <= (36'(s2_t_a) + 36'(s2_t_b) + 36'(s2_t_c)) <<< 1;
      s3_nxa <= 50'(s2_asq) * 50'(s2_dy_bc);
      s3_nxb <= 50'(s2_bsq) * 50'(s2_dy_ca);
      s3_nxc <= 50'(s2_csq) * 50'(s2_dy_ab);
      s3_nya <= 50'(s2_asq) * 50'(s2_dx_cb);
      s3_nyb <= 50'(s2_bsq) * 50'(s2_dx_ac);
      s3_nyc <= 50'(s2_csq) * 50'(s2_dx_ba);
    end
  end

  // stage 4: numerators
  logic signed [15:0] s4_ax, s4_ay, s4_px, s4_py;
  logic signed [35:0] s4_d;
  logic signed [50:0] s4_nx, s4_ny;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ax <= s3_ax;
      s4_ay <= s3_ay;
      s4_px <= s3_px;
      s4_py <= s3_py;
      s4_d  <= s3_d;
      s4_nx <= 51'(s3_nxa) + 51'(s3_nxb) + 51'(s3_nxc);
      s4_ny <= 51'(s3_nya) + 51'(s3_nyb) + 51'(s3_nyc);
    end
  end

  // divider: sign-magnitude, one quotient bit per stage
  ict_pkg::div_t dv [0:DS];
  logic signed [50:0] s4_nx_abs, s4_ny_abs;
  logic signed [35:0] s4_d_abs;

  always_comb begin
    s4_nx_abs = s4_nx[50] ? -s4_nx : s4_nx;
    s4_ny_abs = s4_ny[50] ? -s4_ny : s4_ny;
    s4_d_abs  = s4_d[35] ? -s4_d : s4_d;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].num_x <= s4_nx_abs[NW-1:0];
      dv[0].num_y <= s4_ny_abs[NW-1:0];
      dv[0].q_x   <= '0;
      dv[0].q_y   <= '0;
      dv[0].rem_x <= '0;
      dv[0].rem_y <= '0;
      dv[0].den   <= s4_d_abs[DW-1:0];
      dv[0].neg_x <= s4_nx[50] ^ s4_d[35];
      dv[0].neg_y <= s4_ny[50] ^ s4_d[35];
      dv[0].deg   <= (s4_d == '0);
      dv[0].ax    <= s4_ax;
      dv[0].ay    <= s4_ay;
      dv[0].px    <= s4_px;
      dv[0].py    <= s4_py;
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [DW:0]   stp_x, stp_y;
    ict_pkg::div_t dv_next;
    always_comb begin
      stp_x = ict_pkg::div_step(dv[g].rem_x, dv[g].num_x[NW-1], dv[g].den);
      stp_y = ict_pkg::div_step(dv[g].rem_y, dv[g].num_y[NW-1], dv[g].den);
      dv_next       = dv[g];
      dv_next.num_x = dv[g].num_x << 1;
      dv_next.num_y = dv[g].num_y << 1;
      dv_next.q_x   = {dv[g].q_x[NW-2:0], stp_x[DW]};
      dv_next.q_y   = {dv[g].q_y[NW-2:0], stp_y[DW]};
      dv_next.rem_x = stp_x[DW-1:0];
      dv_next.rem_y = stp_y[DW-1:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[g+1] <= dv_next;
      end
    end
  end

  // signed centre
  logic signed [OW-1:0] qx_s, qy_s, o_ox, o_oy;
  logic signed [15:0]   o_ax, o_ay, o_px, o_py;
  logic                 o_deg;

  assign qx_s = {1'b0, dv[DS].q_x};
  assign qy_s = {1'b0, dv[DS].q_y};

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ox  <= dv[DS].neg_x ? -qx_s : qx_s;
      o_oy  <= dv[DS].neg_y ? -qy_s : qy_s;
      o_ax  <= dv[DS].ax;
      o_ay  <= dv[DS].ay;
      o_px  <= dv[DS].px;
      o_py  <= dv[DS].py;
      o_deg <= dv[DS].deg;
    end
  end

  // offsets from centre, magnitudes, split squares
  // lanes: 0 ax, 1 ay, 2 px, 3 py
  logic signed [ict_pkg::DIFF_W-1:0] e1_d [4];
  logic [MW-1:0]                     e2_m [4];
  logic [2*HW-1:0]                   e3_ll [4];
  logic [2*HW-1:0]                   e3_lh [4];
  logic [2*HW-1:0]                   e3_hh [4];
  logic [ict_pkg::SQ_W-1:0]          e4_sq [4];
  logic signed [OW-1:0]              e_ox [4];
  logic signed [OW-1:0]              e_oy [4];
  logic [3:0]                        e_deg;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_d[0] <= ict_pkg::DIFF_W'(o_ax) - ict_pkg::DIFF_W'(o_ox);
      e1_d[1] <= ict_pkg::DIFF_W'(o_ay) - ict_pkg::DIFF_W'(o_oy);
      e1_d[2] <= ict_pkg::DIFF_W'(o_px) - ict_pkg::DIFF_W'(o_ox);
      e1_d[3] <= ict_pkg::DIFF_W'(o_py) - ict_pkg::DIFF_W'(o_oy);
      e_ox[0] <= o_ox;
      e_oy[0] <= o_oy;
      e_deg[0] <= o_deg;
      for (int i = 1; i < 4; i++) begin
        e_ox[i]  <= e_ox[i-1];
        e_oy[i]  <= e_oy[i-1];
        e_deg[i] <= e_deg[i-1];
      end
      for (int i = 0; i < 4; i++) begin
        e2_m[i]  <= MW'(e1_d[i][ict_pkg::DIFF_W-1] ? -e1_d[i] : e1_d[i]);
        e3_ll[i] <= (2*HW)'(e2_m[i][HW-1:0]) * (2*HW)'(e2_m[i][HW-1:0]);
        e3_lh[i] <= (2*HW)'(e2_m[i][HW-1:0]) * (2*HW)'(e2_m[i][MW-1:HW]);
        e3_hh[i] <= (2*HW)'(e2_m[i][MW-1:HW]) * (2*HW)'(e2_m[i][MW-1:HW]);
        e4_sq[i] <= {e3_hh[i], e3_ll[i]} + (ict_pkg::SQ_W'(e3_lh[i]) << (HW + 1));
      end
    end
  end

  // square roots, two bits of radicand per stage
  ict_pkg::sqr_t sq [0:SS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].rad_a  <= ict_pkg::RAD_W'(e4_sq[0]) + ict_pkg::RAD_W'(e4_sq[1]);
      sq[0].rad_p  <= ict_pkg::RAD_W'(e4_sq[2]) + ict_pkg::RAD_W'(e4_sq[3]);
      sq[0].rem_a  <= '0;
      sq[0].rem_p  <= '0;
      sq[0].root_a <= '0;
      sq[0].root_p <= '0;
      sq[0].deg    <= e_deg[3];
      sq[0].ox     <= e_ox[3];
      sq[0].oy     <= e_oy[3];
    end
  end

  for (genvar g = 0; g < SS; g++) begin : g_sqrt
    logic [ict_pkg::REM_W:0] stp_a, stp_p;
    ict_pkg::sqr_t           sq_next;
    always_comb begin
      stp_a = ict_pkg::sqrt_step(sq[g].rem_a, sq[g].rad_a[ict_pkg::RAD_W-1 -: 2],
                                 sq[g].root_a);
      stp_p = ict_pkg::sqrt_step(sq[g].rem_p, sq[g].rad_p[ict_pkg::RAD_W-1 -: 2],
                                 sq[g].root_p);
      sq_next        = sq[g];
      sq_next.rad_a  = sq[g].rad_a << 2;
      sq_next.rad_p  = sq[g].rad_p << 2;
      sq_next.rem_a  = stp_a[ict_pkg::REM_W-1:0];
      sq_next.rem_p  = stp_p[ict_pkg::REM_W-1:0];
      sq_next.root_a = {sq[g].root_a[RW-2:0], stp_a[ict_pkg::REM_W]};
      sq_next.root_p = {sq[g].root_p[RW-2:0], stp_p[ict_pkg::REM_W]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[g+1] <= sq_next;
      end
    end
  end

  // result word
  logic inside_cmp;

  assign inside_cmp = ((RW+1)'(sq[SS].root_p) + (RW+1)'(inside_margin))
                      < (RW+1)'(sq[SS].root_a);

  always_ff @(posedge clk) begin
    if (adv) begin
      result.degenerate <= sq[SS].deg;
      if (sq[SS].deg) begin
        result.inside_res <= 1'b0;
        result.centre_x   <= '0;
        result.centre_y   <= '0;
        result.radius     <= '0;
      end else begin
        result.inside_res <= inside_cmp;
        result.centre_x   <= ict_pkg::sat_s32(sq[SS].ox);
        result.centre_y   <= ict_pkg::sat_s32(sq[SS].oy);
        result.radius     <= (sq[SS].root_a[RW-1:ict_pkg::OUT_W] != '0) ?
                             '1 : sq[SS].root_a[ict_pkg::OUT_W-1:0];
      end
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      !result.inside_res && result.centre_x == '0 && result.centre_y == '0 &&
      result.radius == '0)
    else $error("degenerate word carries nonzero fields");

  a_inside_radius: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.inside_res |-> result.radius != '0)
    else $error("inside flagged with zero radius");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !adv |=> $stable(dv_v) && $stable(sq_v) && $stable(e_v) && result_valid)
    else $error("pipeline moved during stall");

endmodule

[tb/sv/tb_incircle_test_unit.sv]
// Testbench for incircle_test_unit: directed table, random words, predictor check.
module tb_incircle_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 113;
  localparam int CYC_LIMIT = 300000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    ict_pkg::in_word_t  w;
    bit                 typed;
    ict_pkg::out_word_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic query_valid = 1'b0;
  logic query_ready;
  ict_pkg::in_word_t query = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  ict_pkg::out_word_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ict_pkg::MARGIN_W-1:0] cfg_data = '0;

  ict_pkg::out_word_t expected_q[$];
  logic [ict_pkg::MARGIN_W-1:0] margin_shadow = '0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  row_t dir_rows[$];

  incircle_test_unit DUT (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_ready(query_ready), .query(query),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // floor(sqrt(dx^2 + dy^2)), exact
  function automatic logic [63:0] floor_dist(longint dx, longint dy);
    logic [127:0] mx, my, n, c2;
    logic [63:0] r, cand;
    mx = 128'(dx < 0 ? -dx : dx);
    my = 128'(dy < 0 ? -dy : dy);
    n = mx * mx + my * my;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      c2 = 128'(cand) * 128'(cand);
      if (c2 <= n) r = cand;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic ict_pkg::out_word_t predict_incircle(ict_pkg::in_word_t w,
                                                          logic [ict_pkg::MARGIN_W-1:0] m);
    longint px, py, ax, ay, bx, by, cx, cy, d, asq, bsq, csq, nx, ny, ox, oy;
    logic [63:0] rad, qdist;
    ict_pkg::out_word_t o;
    px = 64'(w.query_x);  py = 64'(w.query_y);
    ax = 64'(w.vert_a_x); ay = 64'(w.vert_a_y);
    bx = 64'(w.vert_b_x); by = 64'(w.vert_b_y);
    cx = 64'(w.vert_c_x); cy = 64'(w.vert_c_y);
    o = '0;
    d = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
    if (d == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    asq = ax * ax + ay * ay;
    bsq = bx * bx + by * by;
    csq = cx * cx + cy * cy;
    nx = asq * (by - cy) + bsq * (cy - ay) + csq * (ay - by);
    ny = asq * (cx - bx) + bsq * (ax - cx) + csq * (bx - ax);
    ox = nx / d;
    oy = ny / d;
    rad = floor_dist(ax - ox, ay - oy);
    qdist = floor_dist(px - ox, py - oy);
    o.inside_res = (qdist + 64'(m) < rad);
    o.centre_x = clamp_s32(ox);
    o.centre_y = clamp_s32(oy);
    o.radius = (rad > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rad[31:0];
    return o;
  endfunction

  task automatic send_word(ict_pkg::in_word_t w, bit typed, ict_pkg::out_word_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query <= w;
    query_valid <= 1'b1;
    do @(posedge clk); while (!query_ready);
    expected_q.push_back(typed ? r : predict_incircle(w, margin_shadow));
  endtask

  task automatic drain();
    query_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_margin(logic [ict_pkg::MARGIN_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    margin_shadow = v;
  endtask

  function automatic ict_pkg::in_word_t random_word();
    ict_pkg::in_word_t w;
    int k, s, mode;
    mode = $urandom_range(0, 9);
    w = ict_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom});
    if (mode >= 3) begin
      s = (mode >= 8) ? 32767 : 2000;
      w.vert_a_x = 16'($urandom_range(0, 2 * s) - s);
      w.vert_a_y = 16'($urandom_range(0, 2 * s) - s);
      w.vert_b_x = 16'($urandom_range(0, 2 * s) - s);
      w.vert_b_y = 16'($urandom_range(0, 2 * s) - s);
      w.vert_c_x = 16'($urandom_range(0, 2 * s) - s);
      w.vert_c_y = 16'($urandom_range(0, 2 * s) - s);
      w.query_x = 16'(w.vert_a_x + $urandom_range(0, 1000) - 500);
      w.query_y = 16'(w.vert_b_y + $urandom_range(0, 1000) - 500);
    end
    if (mode == 9) begin
      // collinear or nearly so
      k = $urandom_range(0, 4) - 2;
      w.vert_a_x = 16'($urandom_range(0, 4000) - 2000);
      w.vert_a_y = 16'($urandom_range(0, 4000) - 2000);
      w.vert_b_x = 16'(w.vert_a_x + $urandom_range(0, 200) - 100);
      w.vert_b_y = 16'(w.vert_a_y + $urandom_range(0, 200) - 100);
      w.vert_c_x = 16'(w.vert_a_x + k * (w.vert_b_x - w.vert_a_x) + $urandom_range(0, 1));
      w.vert_c_y = 16'(w.vert_a_y + k * (w.vert_b_y - w.vert_a_y));
    end
    return w;
  endfunction

  task automatic add_row(int qx, int qy, int ax, int ay, int bx, int by,
                         int cx, int cy, bit typed, ict_pkg::out_word_t r);
    row_t row;
    row.w = '{16'(qx), 16'(qy), 16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(cx), 16'(cy)};
    row.typed = typed;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  // result receiver
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    ict_pkg::out_word_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", result);
      end else begin
        e = expected_q.pop_front();
        if (result.inside_res !== e.inside_res || result.degenerate !== e.degenerate ||
            result.centre_x !== e.centre_x || result.centre_y !== e.centre_y ||
            result.radius !== e.radius) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, result);
        end
      end
    end
  end

  initial begin
    ict_pkg::out_word_t degen, none;
    logic [ict_pkg::MARGIN_W-1:0] margins[5];
    degen = '0;
    degen.degenerate = 1'b1;
    none = '0;
    margins = '{16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd1};
    margins[3] = 16'($urandom_range(0, 65535));

    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, degen);
    add_row(5, 5, 0, 0, 256, 256, 512, 512, 1, degen);
    add_row(-32768, 32767, 100, -100, 100, -100, 300, 7, 1, degen);
    add_row(32767, 32767, -32768, -32768, 0, 0, 32767, 32767, 0, none);
    add_row(0, 0, 0, 0, 256, 0, 0, 256, 0, none);
    add_row(128, 128, 0, 0, 256, 0, 0, 256, 0, none);
    add_row(256, 0, 0, 0, 256, 0, 0, 256, 0, none);
    add_row(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0, none);
    add_row(32767, -32768, -32768, -32768, 32767, -32768, -32768, 32767, 0, none);
    add_row(0, 0, -32768, 0, 32767, 1, 32767, 0, 0, none);
    add_row(1, 1, 0, 0, 32767, 1, -32768, -1, 0, none);
    add_row(-1, -1, -32768, -32768, 32767, 32767, 32766, 32767, 0, none);
    add_row(-32768, 0, -300, -300, 300, -300, 0, 300, 0, none);
    add_row(10, -20, -500, 40, 700, -90, 33, 800, 0, none);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_margin(margins[ph]);
      foreach (dir_rows[i]) if (!dir_rows[i].typed) send_word(dir_rows[i].w, 0, none);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 215; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(random_word(), 0, none);
      end
      no_idle = 0;
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
